[design/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

  localparam int POOL_BLOCKS = 256;
  localparam int TREE_LEVELS = 9;
  localparam int BLOCK_SHIFT = 8;
  localparam int NODE_COUNT  = 2 * POOL_BLOCKS - 1;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int LEAF_W      = $clog2(POOL_BLOCKS);
  localparam int LEAF_FIRST  = POOL_BLOCKS - 1;
  localparam int ORDER_W     = 5;
  localparam int NEED_W      = 4;
  localparam int COUNT_W     = 9;
  localparam int BLOCKS_W    = 10;

  localparam logic [ORDER_W-1:0] BUSY_MARK = 5'd31;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [16:0] request_bytes;
    logic [15:0] region_address;
  } in_t;

  typedef struct packed {
    logic        success;
    logic [15:0] granted_address;
    logic [8:0]  free_blocks_left;
  } out_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NEED_W-1:0] need;
    logic [LEAF_W-1:0] leaf;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_CHK,
    ST_A_RIGHT,
    ST_A_PICK,
    ST_A_MARK,
    ST_F_CHK,
    ST_UP,
    ST_DONE
  } state_t;

  function automatic logic signed [5:0] rank(input logic [ORDER_W-1:0] v);
    rank = (v == BUSY_MARK) ? -6'sd1 : $signed({1'b0, v});
  endfunction

  function automatic logic fits(input logic [ORDER_W-1:0] v, input logic [NEED_W-1:0] need);
    fits = (v != BUSY_MARK) && (v >= ORDER_W'(need));
  endfunction

endpackage

[design/bba_ram.sv]
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/bba_front.sv]
`timescale 1ns / 1ps

module bba_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bba_pkg::in_t  in_item,
  input  logic          hold,
  output logic          in_stall,
  input  logic          pop,
  output logic          cmd_valid,
  output bba_pkg::cmd_t cmd
);

  logic [bba_pkg::BLOCKS_W-1:0] blocks;
  logic [bba_pkg::NEED_W-1:0]   need;
  bba_pkg::cmd_t                cls;
  bba_pkg::cmd_t                q [2];
  logic                         rd_ptr;
  logic                         wr_ptr;
  logic [1:0]                   cnt;
  logic                         push;

  always_comb begin
    blocks = bba_pkg::BLOCKS_W'((18'(in_item.request_bytes) + 18'd255) >> bba_pkg::BLOCK_SHIFT);
    need = '0;
    for (int k = bba_pkg::BLOCKS_W - 1; k >= 0; k--) begin
      if ((11'd1 << k) >= 11'(blocks)) begin
        need = bba_pkg::NEED_W'(k);
      end
    end
    cls.need = need;
    cls.leaf = in_item.region_address[15:bba_pkg::BLOCK_SHIFT];
    if (in_item.mode == bba_pkg::MODE_FREE) begin
      cls.op = (in_item.region_address[bba_pkg::BLOCK_SHIFT-1:0] != '0) ?
               bba_pkg::OP_REJECT : bba_pkg::OP_FREE;
    end else begin
      cls.op = (blocks == '0) ? bba_pkg::OP_REJECT : bba_pkg::OP_ALLOC;
    end
  end

  assign in_stall  = hold || (cnt == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

[design/bba_back.sv]
`timescale 1ns / 1ps

module bba_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  bba_pkg::cmd_t cmd,
  output logic          pop,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_stall,
  output bba_pkg::out_t out_item
);

  localparam int NW = bba_pkg::NODE_W;
  localparam int OW = bba_pkg::ORDER_W;

  bba_pkg::state_t state;
  bba_pkg::state_t state_next;

  logic [NW-1:0]               clr_idx;
  logic [NW-1:0]               cur;
  logic [OW-1:0]               curv;
  logic [OW-1:0]               nodeval;
  logic [OW-1:0]               lv;
  logic [OW-1:0]               lvl;
  logic [bba_pkg::LEAF_W-1:0]  pos;
  logic [bba_pkg::NEED_W-1:0]  need;
  logic                        merge;
  logic                        success;
  logic [15:0]                 addr;
  logic [bba_pkg::COUNT_W-1:0] count;

  logic          we;
  logic [NW-1:0] waddr;
  logic [OW-1:0] wdata;
  logic [NW-1:0] raddr;
  logic [OW-1:0] rdata;

  logic [NW-1:0]      left_n;
  logic [NW-1:0]      right_n;
  logic [NW-1:0]      parent_n;
  logic [NW-1:0]      sib_n;
  logic [NW-1:0]      psib_n;
  logic               pick_any;
  logic               pick_right;
  logic [NW-1:0]      pick_n;
  logic [OW-1:0]      pick_v;
  logic [OW-1:0]      up_val;
  logic [OW-1:0]      init_val;
  logic [5:0]         shamt;
  logic [15:0]        grant;
  logic               out_load;

  bba_ram #(.WIDTH(OW), .DEPTH(bba_pkg::NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  function automatic logic [NW-1:0] sibling(input logic [NW-1:0] n);
    sibling = n[0] ? n + NW'(1) : n - NW'(1);
  endfunction

  function automatic logic [bba_pkg::COUNT_W-1:0] pow2(input logic [OW-1:0] l);
    pow2 = (l < OW'(bba_pkg::COUNT_W)) ? (bba_pkg::COUNT_W'(1) << l) : '0;
  endfunction

  always_comb begin
    logic [NW:0]               np1;
    logic [3:0]                depth;
    logic signed [5:0]         ra;
    logic signed [5:0]         rb;
    logic signed [5:0]         m;
    logic                      fl;
    logic                      fr;
    np1   = {1'b0, clr_idx} + (NW + 1)'(1);
    depth = '0;
    for (int k = 0; k <= NW; k++) begin
      if (np1[k]) begin
        depth = 4'(k);
      end
    end
    init_val = OW'(bba_pkg::TREE_LEVELS - 1) - OW'(depth);

    left_n   = {cur[NW-2:0], 1'b1};
    right_n  = {cur[NW-2:0], 1'b0} + NW'(2);
    parent_n = (cur - NW'(1)) >> 1;
    sib_n    = sibling(cur);
    psib_n   = sibling(parent_n);

    fl = bba_pkg::fits(lv, need);
    fr = bba_pkg::fits(rdata, need);
    if (bba_pkg::rank(lv) <= bba_pkg::rank(rdata)) begin
      pick_any   = fl || fr;
      pick_right = !fl;
    end else begin
      pick_any   = fl || fr;
      pick_right = fr;
    end
    pick_n = pick_right ? right_n : left_n;
    pick_v = pick_right ? rdata : lv;

    ra = bba_pkg::rank(nodeval);
    rb = bba_pkg::rank(rdata);
    if (ra > rb) begin
      m = ra;
    end else if (ra < rb) begin
      m = rb;
    end else if (merge && (ra == $signed({1'b0, lvl}))) begin
      m = $signed({1'b0, lvl}) + 6'sd1;
    end else begin
      m = ra;
    end
    up_val = (m < 0) ? bba_pkg::BUSY_MARK : m[OW-1:0];

    shamt = 6'(curv) + 6'(bba_pkg::BLOCK_SHIFT);
    grant = (shamt >= 6'd16) ? 16'd0 : (16'(pos) << shamt[3:0]);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        if (clr_idx == NW'(bba_pkg::NODE_COUNT - 1)) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            bba_pkg::OP_ALLOC: state_next = bba_pkg::ST_A_CHK;
            bba_pkg::OP_FREE:  state_next = bba_pkg::ST_F_CHK;
            default:           state_next = bba_pkg::ST_DONE;
          endcase
        end
      end
      bba_pkg::ST_A_CHK: begin
        state_next = bba_pkg::fits(rdata, need) ? bba_pkg::ST_A_RIGHT : bba_pkg::ST_DONE;
      end
      bba_pkg::ST_A_RIGHT: state_next = bba_pkg::ST_A_PICK;
      bba_pkg::ST_A_PICK: begin
        if (pick_any && (pick_n < NW'(bba_pkg::LEAF_FIRST))) begin
          state_next = bba_pkg::ST_A_RIGHT;
        end else begin
          state_next = bba_pkg::ST_A_MARK;
        end
      end
      bba_pkg::ST_A_MARK: begin
        state_next = (cur == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_UP;
      end
      bba_pkg::ST_F_CHK: begin
        if (rdata == bba_pkg::BUSY_MARK) begin
          state_next = (cur == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_UP;
        end else if (cur == '0) begin
          state_next = bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_UP: begin
        if (parent_n == '0) begin
          state_next = bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: state_next = bba_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = cur;
    wdata    = init_val;
    raddr    = '0;
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
      end
      bba_pkg::ST_IDLE: begin
        pop   = cmd_valid;
        raddr = (cmd.op == bba_pkg::OP_FREE) ?
                NW'(cmd.leaf) + NW'(bba_pkg::LEAF_FIRST) : '0;
      end
      bba_pkg::ST_A_CHK:   raddr = left_n;
      bba_pkg::ST_A_RIGHT: raddr = right_n;
      bba_pkg::ST_A_PICK:  raddr = {pick_n[NW-2:0], 1'b1};
      bba_pkg::ST_A_MARK: begin
        we    = 1'b1;
        wdata = bba_pkg::BUSY_MARK;
        raddr = sib_n;
      end
      bba_pkg::ST_F_CHK: begin
        if (rdata == bba_pkg::BUSY_MARK) begin
          we    = 1'b1;
          wdata = lvl;
          raddr = sib_n;
        end else begin
          raddr = parent_n;
        end
      end
      bba_pkg::ST_UP: begin
        we    = 1'b1;
        waddr = parent_n;
        wdata = up_val;
        raddr = psib_n;
      end
      bba_pkg::ST_DONE: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign clearing = (state == bba_pkg::ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::ST_CLEAR;
      clr_idx   <= '0;
      count     <= bba_pkg::COUNT_W'(bba_pkg::POOL_BLOCKS);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bba_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + NW'(1);
      end
      if (state == bba_pkg::ST_A_MARK) begin
        count <= count - pow2(curv);
      end
      if ((state == bba_pkg::ST_F_CHK) && (rdata == bba_pkg::BUSY_MARK)) begin
        count <= count + pow2(lvl);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bba_pkg::ST_IDLE: begin
        need    <= cmd.need;
        pos     <= '0;
        lvl     <= '0;
        success <= 1'b0;
        addr    <= '0;
        cur     <= (cmd.op == bba_pkg::OP_FREE) ?
                   NW'(cmd.leaf) + NW'(bba_pkg::LEAF_FIRST) : '0;
      end
      bba_pkg::ST_A_CHK: curv <= rdata;
      bba_pkg::ST_A_RIGHT: lv <= rdata;
      bba_pkg::ST_A_PICK: begin
        if (pick_any) begin
          cur  <= pick_n;
          curv <= pick_v;
          pos  <= {pos[bba_pkg::LEAF_W-2:0], pick_right};
        end
      end
      bba_pkg::ST_A_MARK: begin
        success <= 1'b1;
        addr    <= grant;
        nodeval <= bba_pkg::BUSY_MARK;
        merge   <= 1'b0;
      end
      bba_pkg::ST_F_CHK: begin
        if (rdata == bba_pkg::BUSY_MARK) begin
          success <= 1'b1;
          nodeval <= lvl;
          merge   <= 1'b1;
        end else if (cur != '0) begin
          cur <= parent_n;
          lvl <= lvl + OW'(1);
        end
      end
      bba_pkg::ST_UP: begin
        cur     <= parent_n;
        nodeval <= up_val;
        lvl     <= lvl + OW'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      out_item.success          <= success;
      out_item.granted_address  <= addr;
      out_item.free_blocks_left <= count;
    end
  end

endmodule

[design/buddy_block_allocator_core.sv]
`timescale 1ns / 1ps
// Binary buddy allocator over 256 blocks of 256 bytes, kept as a 511-node max-order tree
// in a single RAM with one write and one registered read port.
// Input channel (in_valid, in_stall, in_item): mode 0 allocates request_bytes, mode 1
// frees the region holding region_address. A transfer takes place when valid is high
// and stall is low. Items are classified on entry and wait in a two-entry queue.
// Output channel (out_valid, out_stall, out_item): one result per item, carrying
// success, the granted byte address and the free block count after the item.
// An allocate reads the left and then the right child at each tree level on the way down,
// marks the chosen node busy and updates its parents on the way up to the root; a free
// climbs from the leaf until it finds the busy node, frees it and updates its parents on
// the way back up to the root. Rejected items and allocates that do not fit skip the walk.
// The single RAM read port sets this pace; one item is worked on at a time
// while the next waits in the queue.
// After reset a clearing pass writes every tree node with its order;
// in_stall stays high during it.
// When out_stall is high the finished result holds in the output register; the
// engine then waits to deliver its next result while the queue takes items until full.

module buddy_block_allocator_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bba_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output bba_pkg::out_t out_item
);

  logic          cmd_valid;
  bba_pkg::cmd_t cmd;
  logic          pop;
  logic          clearing;

  bba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .hold      (clearing),
    .in_stall  (in_stall),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  bba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_reset_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled during clearing pass");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.success) |-> (out_item.granted_address == 16'd0))
    else $error("failed item carries an address");

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> cmd_valid)
    else $error("queue read while empty");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!pop && !out_valid))
    else $error("work started during clearing pass");

endmodule
